@@ hdl/isrp_pkg.sv @@
// Shared types, codes and the damageable-id lookup for the slot record parser.
package isrp_pkg;

   typedef enum logic [4:0] {
      PH_ID      = 5'b00001,
      PH_COUNT   = 5'b00010,
      PH_META    = 5'b00100,
      PH_LEN     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_COMPLETE  = 2'd1;
   localparam logic [1:0] KIND_MALFORMED = 2'd2;

   localparam logic [15:0] WORD_MINUS_ONE = 16'hFFFF;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [15:0] item_id;
      logic signed [7:0]  item_count;
      logic signed [15:0] meta_value;
      logic signed [15:0] payload_length;
      logic [7:0]         payload_byte;
      logic               has_payload;
      logic               record_end;
   } result_type;

   function automatic logic is_damageable(input logic [15:0] id);
      return id inside {[16'd256:16'd259], 16'd261, [16'd267:16'd279],
                        [16'd283:16'd286], [16'd290:16'd294], [16'd298:16'd317],
                        16'd346, 16'd359};
   endfunction

endpackage

@@ hdl/item_slot_record_parser_core.sv @@
// Top level of the slot record parser: byte-wide record state machine and result buffer.
//
//   channel | direction | payload                                    | flow
//   req_    | in        | in_byte (8)                                | valid/ready
//   rsp_    | out       | kind, id, count, meta, length, byte, flags | valid/ready
//
// Each accepted byte advances the record state in the same cycle; a result, when the
// byte produces one, is registered on rsp_, or in the skid entry while rsp_ is stalled.
// One byte per cycle sustained while the skid entry is empty and req_ready stays high.
// Synchronous reset returns to waiting for an item id and empties the result buffer.
// The result side has an output register plus one skid entry, so a stalled rsp_ready
// stops req_ready only once both entries hold results.
module item_slot_record_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic signed [15:0] rsp_item_id,
   output logic signed [7:0]  rsp_item_count,
   output logic signed [15:0] rsp_meta_value,
   output logic signed [15:0] rsp_payload_length,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_has_payload,
   output logic               rsp_record_end
);
   import isrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        byte_idx_ff, byte_idx_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] meta_ff, meta_in;
   logic [15:0] length_ff, length_in;
   logic [14:0] remaining_ff, remaining_in;
   logic [7:0]  hold_ff, hold_in;

   result_type  main_ff, skid_ff, res;
   logic        main_valid_ff, skid_valid_ff;
   logic        accept, push, pop, emit;
   logic [1:0]  kind;
   logic [7:0]  pbyte;
   logic        has_pl, rec_end;
   logic [15:0] word;

   assign accept = req_valid && req_ready;
   assign pop    = main_valid_ff && rsp_ready;
   assign push   = accept && emit;
   assign word   = {hold_ff, req_in_byte};

   always_comb begin
      phase_in     = phase_ff;
      byte_idx_in  = byte_idx_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      meta_in      = meta_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      hold_in      = hold_ff;
      emit         = 1'b0;
      kind         = KIND_COMPLETE;
      pbyte        = 8'd0;
      has_pl       = 1'b0;
      rec_end      = 1'b0;
      case (phase_ff)
         PH_COUNT: begin
            count_in    = req_in_byte;
            byte_idx_in = 1'b0;
            phase_in    = PH_META;
         end
         PH_META: begin
            if (!byte_idx_ff) begin
               hold_in     = req_in_byte;
               byte_idx_in = 1'b1;
            end else begin
               meta_in     = word;
               byte_idx_in = 1'b0;
               if (!is_damageable(id_ff)) begin
                  length_in = 16'd0;
                  phase_in  = PH_ID;
                  emit      = 1'b1;
                  rec_end   = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (!byte_idx_ff) begin
               hold_in     = req_in_byte;
               byte_idx_in = 1'b1;
            end else begin
               length_in   = word;
               byte_idx_in = 1'b0;
               phase_in    = PH_ID;
               if (word == WORD_MINUS_ONE) begin
                  emit    = 1'b1;
                  rec_end = 1'b1;
               end else if (word[15]) begin
                  emit = 1'b1;
                  kind = KIND_MALFORMED;
               end else if (word == 16'd0) begin
                  emit    = 1'b1;
                  has_pl  = 1'b1;
                  rec_end = 1'b1;
               end else begin
                  remaining_in = word[14:0];
                  phase_in     = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            remaining_in = remaining_ff - 15'd1;
            emit         = 1'b1;
            kind         = KIND_PAYLOAD;
            pbyte        = req_in_byte;
            has_pl       = 1'b1;
            if (remaining_in == 15'd0) begin
               phase_in = PH_ID;
               rec_end  = 1'b1;
            end
         end
         default: begin
            // Unused phase codes behave as waiting for an item id.
            phase_in = PH_ID;
            if (!byte_idx_ff) begin
               hold_in     = req_in_byte;
               byte_idx_in = 1'b1;
            end else begin
               id_in        = word;
               byte_idx_in  = 1'b0;
               count_in     = 8'd0;
               meta_in      = 16'd0;
               length_in    = 16'd0;
               remaining_in = 15'd0;
               if (word == WORD_MINUS_ONE) begin
                  emit    = 1'b1;
                  rec_end = 1'b1;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
         end
      endcase
      res.result_kind    = kind;
      res.item_id        = id_in;
      res.item_count     = count_in;
      res.meta_value     = meta_in;
      res.payload_length = length_in;
      res.payload_byte   = pbyte;
      res.has_payload    = has_pl;
      res.record_end     = rec_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID;
         byte_idx_ff  <= 1'b0;
         id_ff        <= 16'd0;
         count_ff     <= 8'd0;
         meta_ff      <= 16'd0;
         length_ff    <= 16'd0;
         remaining_ff <= 15'd0;
         hold_ff      <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         byte_idx_ff  <= byte_idx_in;
         id_ff        <= id_in;
         count_ff     <= count_in;
         meta_ff      <= meta_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         hold_ff      <= hold_in;
      end
   end

   // Two-entry result buffer: main is the head, skid catches a result while main stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         main_ff <= skid_valid_ff ? skid_ff : res;
      end else if (!main_valid_ff) begin
         main_ff <= res;
      end
      if (push && main_valid_ff && !pop) begin
         skid_ff <= res;
      end
   end

   assign req_ready          = !skid_valid_ff;
   assign rsp_valid          = main_valid_ff;
   assign rsp_result_kind    = main_ff.result_kind;
   assign rsp_item_id        = main_ff.item_id;
   assign rsp_item_count     = main_ff.item_count;
   assign rsp_meta_value     = main_ff.meta_value;
   assign rsp_payload_length = main_ff.payload_length;
   assign rsp_payload_byte   = main_ff.payload_byte;
   assign rsp_has_payload    = main_ff.has_payload;
   assign rsp_record_end     = main_ff.record_end;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != 15'd0))
      else $error("payload phase entered with no bytes remaining");

   a_count_byte_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_COUNT) |-> !push)
      else $error("count byte produced a result");

   a_malformed_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_MALFORMED) |-> !rsp_record_end)
      else $error("malformed result marked as record end");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the inventory slot record parser.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isrp_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT   = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_in_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic signed [15:0] rsp_item_id;
   logic signed [7:0]  rsp_item_count;
   logic signed [15:0] rsp_meta_value;
   logic signed [15:0] rsp_payload_length;
   logic [7:0]         rsp_payload_byte;
   logic               rsp_has_payload;
   logic               rsp_record_end;

   item_slot_record_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_item_id        (rsp_item_id),
      .rsp_item_count     (rsp_item_count),
      .rsp_meta_value     (rsp_meta_value),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_record_end     (rsp_record_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Parser state as the testbench tracks it.
   phase_type   slot_phase = PH_ID;
   bit          word_half = 1'b0;
   logic [15:0] slot_id = '0;
   logic [7:0]  slot_count = '0;
   logic [15:0] slot_meta = '0;
   logic [15:0] slot_length = '0;
   logic [14:0] bytes_left = '0;
   logic [7:0]  high_hold = '0;

   result_type  awaited_results[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  bytes_sent = 0;
   bit  sender_eager = 1'b0;
   bit  receiver_eager = 1'b0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  stall_left = 0;

   function automatic bit id_takes_damage(input logic [15:0] id);
      if (id >= 16'd256 && id <= 16'd259) return 1'b1;
      if (id == 16'd261) return 1'b1;
      if (id >= 16'd267 && id <= 16'd279) return 1'b1;
      if (id >= 16'd283 && id <= 16'd286) return 1'b1;
      if (id >= 16'd290 && id <= 16'd294) return 1'b1;
      if (id >= 16'd298 && id <= 16'd317) return 1'b1;
      return id == 16'd346 || id == 16'd359;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] pbyte,
                                       input bit has_pl, input bit last);
      result_type r;
      r.result_kind    = kind;
      r.item_id        = slot_id;
      r.item_count     = slot_count;
      r.meta_value     = slot_meta;
      r.payload_length = slot_length;
      r.payload_byte   = pbyte;
      r.has_payload    = has_pl;
      r.record_end     = last;
      awaited_results.push_back(r);
   endfunction

   // Big-endian word assembly; returns 1 once the low byte has arrived.
   function automatic bit take_word(input logic [7:0] b, output logic [15:0] word);
      word = '0;
      if (!word_half) begin
         high_hold = b;
         word_half = 1'b1;
         return 1'b0;
      end
      word = {high_hold, b};
      word_half = 1'b0;
      return 1'b1;
   endfunction

   function automatic void parse_stream_byte(input logic [7:0] b);
      logic [15:0] word;
      case (slot_phase)
         PH_COUNT: begin
            slot_count = b;
            word_half = 1'b0;
            slot_phase = PH_META;
         end
         PH_META: begin
            if (take_word(b, word)) begin
               slot_meta = word;
               if (!id_takes_damage(slot_id)) begin
                  slot_length = '0;
                  slot_phase = PH_ID;
                  push_result(KIND_COMPLETE, 8'h00, 1'b0, 1'b1);
               end else begin
                  slot_phase = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (take_word(b, word)) begin
               slot_length = word;
               slot_phase = PH_ID;
               if (word == WORD_MINUS_ONE) begin
                  push_result(KIND_COMPLETE, 8'h00, 1'b0, 1'b1);
               end else if (word[15]) begin
                  push_result(KIND_MALFORMED, 8'h00, 1'b0, 1'b0);
               end else if (word == 16'h0000) begin
                  push_result(KIND_COMPLETE, 8'h00, 1'b1, 1'b1);
               end else begin
                  bytes_left = word[14:0];
                  slot_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 15'd1;
            if (bytes_left == '0) begin
               slot_phase = PH_ID;
               push_result(KIND_PAYLOAD, b, 1'b1, 1'b1);
            end else begin
               push_result(KIND_PAYLOAD, b, 1'b1, 1'b0);
            end
         end
         default: begin
            slot_phase = PH_ID;
            if (take_word(b, word)) begin
               slot_id = word;
               slot_count = '0;
               slot_meta = '0;
               slot_length = '0;
               bytes_left = '0;
               if (word == WORD_MINUS_ONE)
                  push_result(KIND_COMPLETE, 8'h00, 1'b0, 1'b1);
               else
                  slot_phase = PH_COUNT;
            end
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Result checker: each transaction on rsp_ is matched against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_error($sformatf("unexpected result of kind %0d", rsp_result_kind));
         end else begin
            want = awaited_results.pop_front();
            check_field("result_kind", int'(rsp_result_kind), int'(want.result_kind));
            check_field("item_id", int'(rsp_item_id), int'(want.item_id));
            check_field("item_count", int'(rsp_item_count), int'(want.item_count));
            check_field("meta_value", int'(rsp_meta_value), int'(want.meta_value));
            check_field("payload_length", int'(rsp_payload_length),
                        int'(want.payload_length));
            check_field("payload_byte", int'(rsp_payload_byte), int'(want.payload_byte));
            check_field("has_payload", int'(rsp_has_payload), int'(want.has_payload));
            check_field("record_end", int'(rsp_record_end), int'(want.record_end));
         end
      end
   end

   // Receiver: random stalls, eager stretches and requested long hold-offs.
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_eager && $urandom_range(0, 2) == 0)
            stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (!req_ready);
      parse_stream_byte(value);
      bytes_sent++;
      gap = sender_eager ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_word(input logic [15:0] word);
      send_byte(word[15:8]);
      send_byte(word[7:0]);
   endtask

   // One record; the length word goes out only for damageable ids, payload bytes only for lengths >= 0.
   task automatic send_slot(input logic [15:0] id, input logic [7:0] count,
                            input logic [15:0] meta, input logic [15:0] len);
      send_word(id);
      if (id != WORD_MINUS_ONE) begin
         send_byte(count);
         send_word(meta);
         if (id_takes_damage(id)) begin
            send_word(len);
            if (!len[15])
               repeat (int'(len)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_damageable_id();
      logic [15:0] id;
      do id = 16'($urandom_range(256, 359)); while (!id_takes_damage(id));
      return id;
   endfunction

   function automatic logic [15:0] pick_plain_id();
      logic [15:0] id;
      do begin
         if ($urandom_range(0, 9) < 3) id = 16'($urandom_range(250, 365));
         else id = 16'($urandom_range(0, 65535));
      end while (id_takes_damage(id) || id == WORD_MINUS_ONE);
      return id;
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return WORD_MINUS_ONE;
      if (r < 22) return 16'h8000 | 16'($urandom_range(0, 16'h7FFE));
      if (r < 32) return 16'h0000;
      if (r < 85) return 16'($urandom_range(1, 6));
      if (r < 97) return 16'($urandom_range(7, 40));
      return 16'($urandom_range(100, 250));
   endfunction

   task automatic send_random_record();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         send_word(WORD_MINUS_ONE);
      end else if (r < 35) begin
         send_slot(pick_plain_id(), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), '0);
      end else if (r < 92) begin
         send_slot(pick_damageable_id(), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), pick_length());
      end else begin
         // Raw noise, then filler bytes until the parser is back at a record boundary.
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         while (!(slot_phase == PH_ID && !word_half))
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_empty_slot();
      send_word(WORD_MINUS_ONE);
      wait_for_results();
   endtask

   task automatic test_plain_items();
      send_slot(16'h8000, 8'h80, 16'h7FFF, '0);
      send_slot(16'h7FFF, 8'h7F, 16'h8000, '0);
      wait_for_results();
   endtask

   task automatic test_damageable_lengths();
      send_slot(16'd256, 8'h00, 16'h0000, WORD_MINUS_ONE);
      send_slot(16'd359, 8'hFF, 16'hFFFF, 16'h0000);
      send_slot(16'd267, 8'h01, 16'h0102, 16'h0002);
      wait_for_results();
   endtask

   task automatic test_malformed_length();
      send_slot(16'd317, 8'h40, 16'h1234, 16'h8000);
      send_slot(16'd346, 8'h02, 16'h00FF, 16'hFFFE);
      wait_for_results();
   endtask

   // The receiver holds off while a long payload keeps coming, so req_ready must drop.
   task automatic test_output_backpressure();
      hold_seq++;
      sender_eager = 1'b1;
      send_slot(16'd300, 8'h05, 16'h0010, 16'd24);
      sender_eager = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_records(input int budget, input bit eager_tx,
                                      input bit eager_rx);
      int stop_at;
      stop_at = bytes_sent + budget;
      sender_eager = eager_tx;
      receiver_eager = eager_rx;
      while (bytes_sent < stop_at) send_random_record();
      wait_for_results();
      sender_eager = 1'b0;
      receiver_eager = 1'b0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_empty_slot();
      test_plain_items();
      test_damageable_lengths();
      test_malformed_length();
      test_output_backpressure();
      test_random_records(500, 1'b0, 1'b0);
      test_random_records(400, 1'b1, 1'b1);
      test_random_records(350, 1'b1, 1'b0);
      test_random_records(350, 1'b0, 1'b1);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/isrp_pkg.sv
hdl/item_slot_record_parser_core.sv
verif/testbench.sv
